// ----- src/tle_pkg.sv -----
// shared types and constants of the terminal line editor
package tle_pkg;

    // default depth of the line store
    localparam int STORE_DEPTH_DEF = 64;

    // configuration port
    localparam int CFG_DATA_W = 16;
    localparam logic CFG_MAX_LEN     = 1'b0;
    localparam logic CFG_ESC_TIMEOUT = 1'b1;
    localparam logic [6:0]  MAX_LEN_RST     = 7'd64;
    localparam logic [15:0] ESC_TIMEOUT_RST = 16'd1000;

    // item kinds
    localparam logic [2:0] KIND_BEGIN  = 3'd0;
    localparam logic [2:0] KIND_PRESET = 3'd1;
    localparam logic [2:0] KIND_RECV   = 3'd2;
    localparam logic [2:0] KIND_TICK   = 3'd3;
    localparam logic [2:0] KIND_READ   = 3'd4;

    // character codes
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_ESC   = 8'h1B;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_LBRK  = 8'h5B;
    localparam logic [7:0] CH_C     = 8'h43;
    localparam logic [7:0] CH_D     = 8'h44;

    // result job handed from the control logic to the output sequencer
    typedef struct packed {
        logic       valid;
        logic [1:0] last_idx;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic       rd;
        logic       rd_hit;
        logic       fin;
        logic [7:0] key;
        logic [5:0] len;
    } job_t;

endpackage

// ----- src/tle_ram.sv -----
// generic single-port-write, registered-read ram
module tle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/tle_ctrl.sv -----
// editor state, configuration registers and per-item decisions
module tle_ctrl #(
    parameter int STORE_DEPTH = tle_pkg::STORE_DEPTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic                            cfg_index,
    input  logic [tle_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                            accept,
    input  logic [2:0]                      kind,
    input  logic [7:0]                      data_byte,
    input  logic [5:0]                      read_index,
    output tle_pkg::job_t                   job,
    output logic                            ram_we,
    output logic [$clog2(STORE_DEPTH)-1:0]  ram_waddr,
    output logic [7:0]                      ram_wdata,
    output logic                            ram_re,
    output logic [$clog2(STORE_DEPTH)-1:0]  ram_raddr
);

    localparam int POS_W = $clog2(STORE_DEPTH);
    localparam int LIM_W = ((POS_W > 7) ? POS_W : 7) + 1;
    localparam int WID_W = POS_W + 6;

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_EDIT,
        MODE_ESC,
        MODE_CSI
    } mode_t;

    mode_t            mode_reg, mode_next;
    logic [POS_W-1:0] cursor_reg, cursor_next;
    logic [POS_W-1:0] length_reg, length_next;
    logic [15:0]      wait_reg, wait_next;
    logic [6:0]       max_len_reg;
    logic [15:0]      esc_timeout_reg;

    logic [LIM_W-1:0] lim_len;
    logic [LIM_W-1:0] lim_cap;
    logic [LIM_W-1:0] limit;
    logic [WID_W-1:0] ri_wide;
    logic [WID_W-1:0] len_wide;
    logic             rd_hit;

    // line end: LF then CR, both tagged with the key
    function automatic tle_pkg::job_t finish_job(input logic [7:0] key);
        tle_pkg::job_t j;
        j = '0;
        j.valid    = 1'b1;
        j.last_idx = 2'd1;
        j.b0       = tle_pkg::CH_LF;
        j.b1       = tle_pkg::CH_CR;
        j.fin      = 1'b1;
        j.key      = key;
        return j;
    endfunction

    // three echo bytes
    function automatic tle_pkg::job_t triple_job(input logic [7:0] a, input logic [7:0] b,
                                                 input logic [7:0] c);
        tle_pkg::job_t j;
        j = '0;
        j.valid    = 1'b1;
        j.last_idx = 2'd2;
        j.b0       = a;
        j.b1       = b;
        j.b2       = c;
        return j;
    endfunction

    // one echo byte
    function automatic tle_pkg::job_t single_job(input logic [7:0] a);
        tle_pkg::job_t j;
        j = '0;
        j.valid = 1'b1;
        j.b0    = a;
        return j;
    endfunction

    // typing limit: max_len - 1, capped by the store
    assign lim_len = (max_len_reg == 7'd0) ? '0 : LIM_W'(max_len_reg) - LIM_W'(1);
    assign lim_cap = LIM_W'(STORE_DEPTH - 1);
    assign limit   = (lim_len < lim_cap) ? lim_len : lim_cap;

    // read-back address; positions at or beyond the length read as zero
    assign ri_wide   = WID_W'(read_index);
    assign rd_hit    = ri_wide < WID_W'(length_reg);
    assign ram_raddr = ri_wide[POS_W-1:0];

    // next state and result job of the accepted item
    always_comb begin
        mode_next   = mode_reg;
        cursor_next = cursor_reg;
        length_next = length_reg;
        wait_next   = wait_reg;
        job         = '0;
        ram_we      = 1'b0;
        ram_waddr   = cursor_reg;
        ram_wdata   = data_byte;
        ram_re      = 1'b0;
        if (accept) begin
            unique case (kind)
                tle_pkg::KIND_BEGIN: begin
                    cursor_next = '0;
                    length_next = '0;
                    mode_next   = MODE_EDIT;
                end
                tle_pkg::KIND_PRESET: begin
                    if (mode_reg == MODE_EDIT && data_byte != tle_pkg::CH_NUL &&
                        LIM_W'(length_reg) < limit) begin
                        ram_we      = 1'b1;
                        ram_waddr   = length_reg;
                        length_next = length_reg + POS_W'(1);
                        cursor_next = length_reg + POS_W'(1);
                        job         = single_job(data_byte);
                    end
                end
                tle_pkg::KIND_RECV: begin
                    unique case (mode_reg)
                        MODE_EDIT: begin
                            if (data_byte == tle_pkg::CH_ESC) begin
                                mode_next = MODE_ESC;
                                wait_next = esc_timeout_reg;
                            end else if (data_byte == tle_pkg::CH_LF ||
                                         data_byte == tle_pkg::CH_CR) begin
                                mode_next = MODE_IDLE;
                                job       = finish_job(data_byte);
                            end else if (data_byte == tle_pkg::CH_BS) begin
                                if (cursor_reg != '0) begin
                                    if (cursor_reg == length_reg) begin
                                        length_next = length_reg - POS_W'(1);
                                    end
                                    cursor_next = cursor_reg - POS_W'(1);
                                    job = triple_job(tle_pkg::CH_BS, tle_pkg::CH_SPACE,
                                                     tle_pkg::CH_BS);
                                end
                            end else if (cursor_reg == '0 &&
                                         data_byte == tle_pkg::CH_SPACE) begin
                                // leading space dropped
                            end else if (LIM_W'(cursor_reg) < limit) begin
                                ram_we = 1'b1;
                                if (cursor_reg == length_reg) begin
                                    length_next = length_reg + POS_W'(1);
                                end
                                cursor_next = cursor_reg + POS_W'(1);
                                job         = single_job(data_byte);
                            end
                        end
                        MODE_ESC: begin
                            if (data_byte == tle_pkg::CH_LBRK) begin
                                mode_next = MODE_CSI;
                                wait_next = esc_timeout_reg;
                            end else begin
                                mode_next = MODE_IDLE;
                                job       = finish_job(tle_pkg::CH_ESC);
                            end
                        end
                        MODE_CSI: begin
                            mode_next = MODE_EDIT;
                            if (data_byte == tle_pkg::CH_D && cursor_reg != '0) begin
                                cursor_next = cursor_reg - POS_W'(1);
                                job = triple_job(tle_pkg::CH_ESC, tle_pkg::CH_LBRK,
                                                 tle_pkg::CH_D);
                            end else if (data_byte == tle_pkg::CH_C &&
                                         cursor_reg < length_reg) begin
                                cursor_next = cursor_reg + POS_W'(1);
                                job = triple_job(tle_pkg::CH_ESC, tle_pkg::CH_LBRK,
                                                 tle_pkg::CH_C);
                            end
                        end
                        default: begin
                            // idle: received bytes ignored
                        end
                    endcase
                end
                tle_pkg::KIND_TICK: begin
                    if (mode_reg == MODE_ESC || mode_reg == MODE_CSI) begin
                        if (wait_reg == 16'd0) begin
                            if (mode_reg == MODE_ESC) begin
                                mode_next = MODE_IDLE;
                                job       = finish_job(tle_pkg::CH_ESC);
                            end else begin
                                mode_next = MODE_EDIT;
                            end
                        end else begin
                            wait_next = wait_reg - 16'd1;
                        end
                    end
                end
                tle_pkg::KIND_READ: begin
                    ram_re     = 1'b1;
                    job.valid  = 1'b1;
                    job.rd     = 1'b1;
                    job.rd_hit = rd_hit;
                end
                default: begin
                    // unknown kinds ignored
                end
            endcase
        end
        len_wide = WID_W'(length_next);
        job.len  = len_wide[5:0];
    end

    // state and configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg        <= MODE_IDLE;
            cursor_reg      <= '0;
            length_reg      <= '0;
            wait_reg        <= '0;
            max_len_reg     <= tle_pkg::MAX_LEN_RST;
            esc_timeout_reg <= tle_pkg::ESC_TIMEOUT_RST;
        end else begin
            mode_reg   <= mode_next;
            cursor_reg <= cursor_next;
            length_reg <= length_next;
            wait_reg   <= wait_next;
            if (cfg_we) begin
                unique case (cfg_index)
                    tle_pkg::CFG_MAX_LEN:     max_len_reg     <= cfg_wdata[6:0];
                    tle_pkg::CFG_ESC_TIMEOUT: esc_timeout_reg <= cfg_wdata[15:0];
                    default: ;
                endcase
            end
        end
    end

endmodule

// ----- src/tle_out.sv -----
// output sequencer: holds one result job and emits its items in order
module tle_out (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          accept,
    input  tle_pkg::job_t job_in,
    input  logic [7:0]    ram_rdata,
    output logic          s_ready,
    output logic          m_valid,
    input  logic          m_ready,
    output logic [7:0]    m_out_byte,
    output logic          m_out_kind,
    output logic          m_line_done,
    output logic [7:0]    m_end_key,
    output logic [5:0]    m_line_length,
    output logic          m_last
);

    logic          valid_reg;
    tle_pkg::job_t job_reg;
    logic [1:0]    idx_reg;
    logic          is_last;
    logic          done_job;
    logic [7:0]    echo_byte;

    assign is_last  = idx_reg == job_reg.last_idx;
    assign done_job = valid_reg && m_ready && is_last;
    assign s_ready  = !valid_reg || done_job;

    // job slot and item index
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end else if (accept && job_in.valid) begin
            valid_reg <= 1'b1;
            idx_reg   <= '0;
        end else if (done_job) begin
            valid_reg <= 1'b0;
        end else if (valid_reg && m_ready) begin
            idx_reg <= idx_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && job_in.valid) begin
            job_reg <= job_in;
        end
    end

    // byte of the current item
    always_comb begin
        unique case (idx_reg)
            2'd0:    echo_byte = job_reg.b0;
            2'd1:    echo_byte = job_reg.b1;
            default: echo_byte = job_reg.b2;
        endcase
    end

    assign m_valid       = valid_reg;
    assign m_out_byte    = job_reg.rd ? (job_reg.rd_hit ? ram_rdata : 8'h00) : echo_byte;
    assign m_out_kind    = job_reg.rd;
    assign m_line_done   = job_reg.fin && is_last;
    assign m_end_key     = job_reg.key;
    assign m_line_length = job_reg.len;
    assign m_last        = is_last;

endmodule

// ----- src/terminal_line_editor.sv -----
// top level of the terminal line editor
// timing: the first result item is presented in the cycle after the input item is accepted
// throughput: an item causes zero to three result items, one per cycle while m_ready is high; the next
//   item is accepted in the cycle the last result of the previous one is taken,
//   and items without results are taken every cycle (set by the one-job output slot)
// reset: synchronous active-low clears cursor, length, mode, wait count and the
//   output slot and loads the configuration defaults; line store contents stay undefined
module terminal_line_editor #(
    parameter int STORE_DEPTH = tle_pkg::STORE_DEPTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic                           cfg_index,
    input  logic [tle_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [2:0]                     s_kind,
    input  logic [7:0]                     s_data_byte,
    input  logic [5:0]                     s_read_index,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [7:0]                     m_out_byte,
    output logic                           m_out_kind,
    output logic                           m_line_done,
    output logic [7:0]                     m_end_key,
    output logic [5:0]                     m_line_length,
    output logic                           m_last
);

    localparam int POS_W = $clog2(STORE_DEPTH);

    logic             accept;
    tle_pkg::job_t    job;
    logic             ram_we;
    logic [POS_W-1:0] ram_waddr;
    logic [7:0]       ram_wdata;
    logic             ram_re;
    logic [POS_W-1:0] ram_raddr;
    logic [7:0]       ram_rdata;

    assign accept = s_valid && s_ready;

    // editor state and decisions
    tle_ctrl #(.STORE_DEPTH(STORE_DEPTH)) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .accept     (accept),
        .kind       (s_kind),
        .data_byte  (s_data_byte),
        .read_index (s_read_index),
        .job        (job),
        .ram_we     (ram_we),
        .ram_waddr  (ram_waddr),
        .ram_wdata  (ram_wdata),
        .ram_re     (ram_re),
        .ram_raddr  (ram_raddr)
    );

    // line store
    tle_ram #(.WIDTH(8), .DEPTH(STORE_DEPTH)) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // result sequencing
    tle_out u_out (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .accept        (accept),
        .job_in        (job),
        .ram_rdata     (ram_rdata),
        .s_ready       (s_ready),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_byte    (m_out_byte),
        .m_out_kind    (m_out_kind),
        .m_line_done   (m_line_done),
        .m_end_key     (m_end_key),
        .m_line_length (m_line_length),
        .m_last        (m_last)
    );

endmodule

// ----- src/tle_checker.sv -----
// port-level assertions for the terminal line editor and their bind
module tle_props (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_out_byte,
    input logic       m_out_kind,
    input logic       m_line_done,
    input logic [7:0] m_end_key,
    input logic [5:0] m_line_length,
    input logic       m_last
);

    // a stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_byte) && $stable(m_last) &&
        $stable(m_line_length))
        else $error("stalled result item changed");

    // no new item while a result is stalled
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("input taken while output stalled");

    // line end closes the item with CR and a valid key
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_line_done |-> m_last && m_out_byte == tle_pkg::CH_CR &&
        (m_end_key == tle_pkg::CH_CR || m_end_key == tle_pkg::CH_LF ||
         m_end_key == tle_pkg::CH_ESC))
        else $error("bad line end item");

    // read-back is a single item that never ends a line
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_out_kind |-> m_last && !m_line_done && m_end_key == tle_pkg::CH_NUL)
        else $error("bad read-back item");

    // the CR of a line end follows its LF
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_end_key != tle_pkg::CH_NUL && !m_line_done |=>
        m_valid && m_line_done)
        else $error("line end CR missing");

endmodule

bind terminal_line_editor tle_props u_chk (.*);
